/* design/rpvg_pkg.sv */
// ----------------------------------------------------------------------------
// rpvg_pkg
// Shared constants, tables and types for the regular polygon vertex generator.
// ----------------------------------------------------------------------------
package rpvg_pkg;

  localparam int SIDE_W             = 7;
  localparam int ANGLE_W            = 16;
  localparam int ROT_W              = 32;
  localparam int Q30_SHIFT          = 30;
  localparam int TABLE_LEN          = 24;
  localparam int MAX_SIDES_DEF      = 64;
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int ROTATION_STEPS_DEF = 16;

  // Inverse CORDIC gain, Q2.30.
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 of a turn.
  localparam logic signed [ROT_W-1:0] ATAN_TURN [TABLE_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } rpvg_quad_t;

  typedef struct packed {
    logic                     vld;
    rpvg_quad_t               quad;
    logic signed [ROT_W-1:0]  x;
    logic signed [ROT_W-1:0]  y;
    logic signed [ROT_W-1:0]  z;
  } rpvg_rot_t;

  typedef struct packed {
    logic start;
    logic step;
  } rpvg_tg_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] angle;
  } rpvg_tg_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_DIVW,
    ST_ISSUE,
    ST_ROT,
    ST_MUL,
    ST_PUT
  } rpvg_state_t;

  typedef enum logic [1:0] {
    TERM_DXC,
    TERM_DYS,
    TERM_DXS,
    TERM_DYC
  } rpvg_term_t;

endpackage

/* design/rpvg_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rpvg_cordic_cell
// One CORDIC micro-rotation with a fixed shift, registered towards the next cell.
// ----------------------------------------------------------------------------
module rpvg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rpvg_pkg::rpvg_rot_t rot_i,
  output rpvg_pkg::rpvg_rot_t rot_o
);
  import rpvg_pkg::*;

  localparam logic signed [ROT_W-1:0] ATAN = ATAN_TURN[STAGE];

  logic                    vld_r;
  logic                    vld_nxt;
  rpvg_rot_t               dat_r;
  rpvg_rot_t               dat_nxt;
  logic signed [ROT_W-1:0] x_in;
  logic signed [ROT_W-1:0] y_in;
  logic signed [ROT_W-1:0] z_in;
  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;

  always_comb begin
    x_in = rot_i.x;
    y_in = rot_i.y;
    z_in = rot_i.z;
    xs   = y_in >>> STAGE;
    ys   = x_in >>> STAGE;
    vld_nxt      = rot_i.vld;
    dat_nxt      = rot_i;
    if (!z_in[ROT_W-1]) begin
      dat_nxt.x = x_in - xs;
      dat_nxt.y = y_in + ys;
      dat_nxt.z = z_in - ATAN;
    end else begin
      dat_nxt.x = x_in + xs;
      dat_nxt.y = y_in - ys;
      dat_nxt.z = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

  always_comb begin
    rot_o     = dat_r;
    rot_o.vld = vld_r;
  end

endmodule

/* design/rpvg_cordic_chain.sv */
// ----------------------------------------------------------------------------
// rpvg_cordic_chain
// Row of CORDIC cells followed by the quadrant fold-out to cosine and sine.
// ----------------------------------------------------------------------------
module rpvg_cordic_chain #(
  parameter int ROTATION_STEPS = rpvg_pkg::ROTATION_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpvg_pkg::rpvg_rot_t               rot_i,
  output logic                              vld_o,
  output logic signed [rpvg_pkg::ROT_W-1:0] cos_o,
  output logic signed [rpvg_pkg::ROT_W-1:0] sin_o
);
  import rpvg_pkg::*;

  rpvg_rot_t               link [ROTATION_STEPS+1];
  logic signed [ROT_W-1:0] fx;
  logic signed [ROT_W-1:0] fy;

  assign link[0] = rot_i;

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
    rpvg_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .rot_i (link[i]),
      .rot_o (link[i+1])
    );
  end

  always_comb begin
    fx    = link[ROTATION_STEPS].x;
    fy    = link[ROTATION_STEPS].y;
    vld_o = link[ROTATION_STEPS].vld;
    case (link[ROTATION_STEPS].quad)
      QUAD_II: begin
        cos_o = -fy;
        sin_o = fx;
      end
      QUAD_III: begin
        cos_o = -fx;
        sin_o = -fy;
      end
      QUAD_IV: begin
        cos_o = fy;
        sin_o = -fx;
      end
      default: begin
        cos_o = fx;
        sin_o = fy;
      end
    endcase
  end

endmodule

/* design/rpvg_turn_gen.sv */
// ----------------------------------------------------------------------------
// rpvg_turn_gen
// Divides a full turn by the side count once, then steps the vertex angle.
// ----------------------------------------------------------------------------
module rpvg_turn_gen #(
  parameter int MAX_SIDES = rpvg_pkg::MAX_SIDES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rpvg_pkg::rpvg_tg_ctrl_t          ctrl_i,
  input  logic [$clog2(MAX_SIDES+1)-1:0]   sides_i,
  output rpvg_pkg::rpvg_tg_stat_t          stat_o
);
  import rpvg_pkg::*;

  localparam int NW    = $clog2(MAX_SIDES + 1);
  localparam int QW    = ANGLE_W + 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic              busy_r;
  logic              busy_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [NW-1:0]     n_r;
  logic [NW-1:0]     n_nxt;
  logic [QW-1:0]     dvd_r;
  logic [QW-1:0]     dvd_nxt;
  logic [NW-1:0]     rem_r;
  logic [NW-1:0]     rem_nxt;
  logic [QW-1:0]     ang_r;
  logic [QW-1:0]     ang_nxt;
  logic [NW-1:0]     arem_r;
  logic [NW-1:0]     arem_nxt;
  logic [NW:0]       trial;
  logic              fits;
  logic [NW:0]       acc_sum;
  logic              wrap;

  always_comb begin
    trial    = {rem_r, dvd_r[QW-1]};
    fits     = (trial >= {1'b0, n_r});
    acc_sum  = {1'b0, arem_r} + {1'b0, rem_r};
    wrap     = (acc_sum >= {1'b0, n_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    ang_nxt  = ang_r;
    arem_nxt = arem_r;
    if (ctrl_i.start) begin
      n_nxt    = sides_i;
      dvd_nxt  = QW'(1) << ANGLE_W;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
      ang_nxt  = '0;
      arem_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? NW'(trial - {1'b0, n_r}) : trial[NW-1:0];
      dvd_nxt  = {dvd_r[QW-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end else if (ctrl_i.step) begin
      arem_nxt = wrap ? NW'(acc_sum - {1'b0, n_r}) : acc_sum[NW-1:0];
      ang_nxt  = ang_r + dvd_r + QW'(wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    n_r    <= n_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    ang_r  <= ang_nxt;
    arem_r <= arem_nxt;
  end

  assign stat_o.done  = !busy_r;
  assign stat_o.angle = ang_r[ANGLE_W-1:0];

endmodule

/* design/regular_polygon_vertex_generator_top.sv */
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator_top
// Emits the vertices of a regular polygon given its centre, one vertex and N.
// ----------------------------------------------------------------------------
// One input beat produces N output beats, vertex 0 being the given vertex and
// vertex k the given vertex rotated about the centre by k/N of a turn, with
// saturated Q16.16 coordinates; N of zero produces nothing and N above
// MAX_SIDES is treated as MAX_SIDES. Items are handled one at a time. Each
// vertex after the first passes through the CORDIC cell row and then four
// products through one shared multiplier; the turn is divided by N once per
// item, overlapped with the first vertex. The next item is taken as soon as
// the last vertex sits in the output register.
module regular_polygon_vertex_generator_top #(
  parameter int MAX_SIDES      = rpvg_pkg::MAX_SIDES_DEF,
  parameter int COORD_WIDTH    = rpvg_pkg::COORD_WIDTH_DEF,
  parameter int ROTATION_STEPS = rpvg_pkg::ROTATION_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_center_x,
  input  logic signed [COORD_WIDTH-1:0]   in_center_y,
  input  logic signed [COORD_WIDTH-1:0]   in_first_x,
  input  logic signed [COORD_WIDTH-1:0]   in_first_y,
  input  logic [rpvg_pkg::SIDE_W-1:0]     in_side_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_WIDTH-1:0]   out_corner_x,
  output logic signed [COORD_WIDTH-1:0]   out_corner_y,
  output logic [$clog2(MAX_SIDES)-1:0]    out_corner_index,
  output logic                            out_last_corner
);
  import rpvg_pkg::*;

  localparam int NW    = $clog2(MAX_SIDES + 1);
  localparam int IDX_W = $clog2(MAX_SIDES);
  localparam int DX_W  = COORD_WIDTH + 1;
  localparam int PW    = DX_W + ROT_W;
  localparam int TRM_W = PW - Q30_SHIFT;
  localparam int ACC_W = COORD_WIDTH + 4;
  localparam int PH_W  = 3;

  localparam logic [PH_W-1:0]         PH_LAST  = PH_W'(4);
  localparam logic signed [PW-1:0]    RND_HALF = PW'(1) << (Q30_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] C_MAX    =
    {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] C_MIN    =
    {{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic [COORD_WIDTH-1:0] r;
    if (v > C_MAX) begin
      r = C_MAX[COORD_WIDTH-1:0];
    end else if (v < C_MIN) begin
      r = C_MIN[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  rpvg_state_t                state_r;
  rpvg_state_t                state_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [COORD_WIDTH-1:0]     out_x_r;
  logic [COORD_WIDTH-1:0]     out_x_nxt;
  logic [COORD_WIDTH-1:0]     out_y_r;
  logic [COORD_WIDTH-1:0]     out_y_nxt;
  logic [IDX_W-1:0]           out_idx_r;
  logic [IDX_W-1:0]           out_idx_nxt;
  logic                       out_last_r;
  logic                       out_last_nxt;
  logic signed [COORD_WIDTH-1:0] cx_r;
  logic signed [COORD_WIDTH-1:0] cx_nxt;
  logic signed [COORD_WIDTH-1:0] cy_r;
  logic signed [COORD_WIDTH-1:0] cy_nxt;
  logic [COORD_WIDTH-1:0]     fx_r;
  logic [COORD_WIDTH-1:0]     fx_nxt;
  logic [COORD_WIDTH-1:0]     fy_r;
  logic [COORD_WIDTH-1:0]     fy_nxt;
  logic signed [DX_W-1:0]     dx_r;
  logic signed [DX_W-1:0]     dx_nxt;
  logic signed [DX_W-1:0]     dy_r;
  logic signed [DX_W-1:0]     dy_nxt;
  logic [NW-1:0]              n_r;
  logic [NW-1:0]              n_nxt;
  logic [NW-1:0]              k_r;
  logic [NW-1:0]              k_nxt;
  logic signed [ROT_W-1:0]    cos_r;
  logic signed [ROT_W-1:0]    cos_nxt;
  logic signed [ROT_W-1:0]    sin_r;
  logic signed [ROT_W-1:0]    sin_nxt;
  logic signed [PW-1:0]       p_r;
  logic signed [PW-1:0]       p_nxt;
  rpvg_term_t                 term_r;
  rpvg_term_t                 term_nxt;
  logic [PH_W-1:0]            ph_r;
  logic [PH_W-1:0]            ph_nxt;
  logic signed [ACC_W-1:0]    accx_r;
  logic signed [ACC_W-1:0]    accx_nxt;
  logic signed [ACC_W-1:0]    accy_r;
  logic signed [ACC_W-1:0]    accy_nxt;

  logic                       in_acc;
  logic                       slot_free;
  logic                       is_last;
  logic [NW-1:0]              sides_clamped;
  logic signed [DX_W-1:0]     mul_a;
  logic signed [ROT_W-1:0]    mul_b;
  logic signed [PW-1:0]       rnd_sum;
  logic signed [TRM_W-1:0]    term_val;
  logic signed [ACC_W-1:0]    term_ext;
  rpvg_tg_ctrl_t              tg_ctrl;
  rpvg_tg_stat_t              tg_stat;
  rpvg_rot_t                  rot_in;
  logic                       chain_vld;
  logic signed [ROT_W-1:0]    chain_cos;
  logic signed [ROT_W-1:0]    chain_sin;

  rpvg_turn_gen #(
    .MAX_SIDES (MAX_SIDES)
  ) u_turn_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (tg_ctrl),
    .sides_i (n_nxt),
    .stat_o  (tg_stat)
  );

  rpvg_cordic_chain #(
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_cordic_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .rot_i (rot_in),
    .vld_o (chain_vld),
    .cos_o (chain_cos),
    .sin_o (chain_sin)
  );

  always_comb begin
    rot_in.vld  = (state_r == ST_ISSUE);
    rot_in.quad = rpvg_quad_t'(tg_stat.angle[ANGLE_W-1 -: 2]);
    rot_in.x    = CORDIC_GAIN;
    rot_in.y    = '0;
    rot_in.z    = {2'b00, tg_stat.angle[ANGLE_W-3:0], {(ROT_W-ANGLE_W){1'b0}}};
  end

  always_comb begin
    case (rpvg_term_t'(ph_r[1:0]))
      TERM_DXC: begin
        mul_a = dx_r;
        mul_b = cos_r;
      end
      TERM_DYS: begin
        mul_a = dy_r;
        mul_b = sin_r;
      end
      TERM_DXS: begin
        mul_a = dx_r;
        mul_b = sin_r;
      end
      default: begin
        mul_a = dy_r;
        mul_b = cos_r;
      end
    endcase
    rnd_sum  = p_r + RND_HALF;
    term_val = $signed(rnd_sum[PW-1:Q30_SHIFT]);
    term_ext = ACC_W'(term_val);
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    in_acc        = in_valid && in_ready;
    slot_free     = !out_valid_r || out_ready;
    is_last       = ((k_r + NW'(1)) == n_r);
    sides_clamped = (in_side_count > SIDE_W'(MAX_SIDES)) ? NW'(MAX_SIDES)
                                                          : NW'(in_side_count);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    cos_nxt       = cos_r;
    sin_nxt       = sin_r;
    p_nxt         = mul_a * mul_b;
    term_nxt      = rpvg_term_t'(ph_r[1:0]);
    ph_nxt        = ph_r;
    accx_nxt      = accx_r;
    accy_nxt      = accy_r;
    tg_ctrl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cx_nxt = in_center_x;
          cy_nxt = in_center_y;
          fx_nxt = in_first_x;
          fy_nxt = in_first_y;
          dx_nxt = DX_W'(in_first_x) - DX_W'(in_center_x);
          dy_nxt = DX_W'(in_first_y) - DX_W'(in_center_y);
          n_nxt  = sides_clamped;
          k_nxt  = '0;
          if (sides_clamped != '0) begin
            tg_ctrl.start = 1'b1;
            state_nxt     = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = fx_r;
          out_y_nxt     = fy_r;
          out_idx_nxt   = k_r[IDX_W-1:0];
          out_last_nxt  = is_last;
          k_nxt         = k_r + NW'(1);
          state_nxt     = is_last ? ST_IDLE : ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (tg_stat.done) begin
          tg_ctrl.step = 1'b1;
          state_nxt    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        if (chain_vld) begin
          cos_nxt   = chain_cos;
          sin_nxt   = chain_sin;
          accx_nxt  = ACC_W'(cx_r);
          accy_nxt  = ACC_W'(cy_r);
          ph_nxt    = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ph_nxt = ph_r + PH_W'(1);
        if (ph_r != '0) begin
          case (term_r)
            TERM_DXC: accx_nxt = accx_r + term_ext;
            TERM_DYS: accx_nxt = accx_r - term_ext;
            TERM_DXS: accy_nxt = accy_r + term_ext;
            default:  accy_nxt = accy_r + term_ext;
          endcase
        end
        if (ph_r == PH_LAST) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = sat_coord(accx_r);
          out_y_nxt     = sat_coord(accy_r);
          out_idx_nxt   = k_r[IDX_W-1:0];
          out_last_nxt  = is_last;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt        = k_r + NW'(1);
            tg_ctrl.step = 1'b1;
            state_nxt    = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ph_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    cos_r      <= cos_nxt;
    sin_r      <= sin_nxt;
    p_r        <= p_nxt;
    term_r     <= term_nxt;
    accx_r     <= accx_nxt;
    accy_r     <= accy_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_corner_x     = out_x_r;
  assign out_corner_y     = out_y_r;
  assign out_corner_index = out_idx_r;
  assign out_last_corner  = out_last_r;

endmodule

/* design/rpvg_checker.sv */
// ----------------------------------------------------------------------------
// rpvg_checker
// Port-level checks on the polygon vertex generator, bound to its top level.
// ----------------------------------------------------------------------------
module rpvg_checker #(
  parameter int MAX_SIDES   = rpvg_pkg::MAX_SIDES_DEF,
  parameter int COORD_WIDTH = rpvg_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rpvg_pkg::SIDE_W-1:0]   in_side_count,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [COORD_WIDTH-1:0]        out_corner_x,
  input logic [COORD_WIDTH-1:0]        out_corner_y,
  input logic [$clog2(MAX_SIDES)-1:0]  out_corner_index,
  input logic                          out_last_corner
);
  import rpvg_pkg::*;

  localparam int IDX_W = $clog2(MAX_SIDES);

  logic             exp_vld_r;
  logic [IDX_W-1:0] exp_idx_r;

  // Within one polygon each beat carries the next vertex number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_vld_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      exp_vld_r <= !out_last_corner;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      exp_idx_r <= out_corner_index + IDX_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_corner_x) &&
    $stable(out_corner_y) && $stable(out_corner_index) && $stable(out_last_corner))
    else $error("Output beat changed while stalled.");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && exp_vld_r |-> out_corner_index == exp_idx_r)
    else $error("Vertex number out of sequence.");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_side_count != '0) |=> !in_ready)
    else $error("Input taken while a polygon is in progress.");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_side_count == '0) |=> in_ready)
    else $error("Empty polygon held the input.");

endmodule

bind regular_polygon_vertex_generator_top rpvg_checker #(
  .MAX_SIDES   (MAX_SIDES),
  .COORD_WIDTH (COORD_WIDTH)
) u_rpvg_checker (.*);

/* tb/rpvg_corner_checker.sv */
// ----------------------------------------------------------------------------
// rpvg_corner_checker
// Watches both channels of the polygon generator and checks every corner beat.
// ----------------------------------------------------------------------------
// Each accepted input beat is expanded into its expected corners. The angle
// for each corner after the first is worked out in turns, then turned into
// cosine and sine by a CORDIC, and the corner is rotated about the centre. The
// expected corners wait in order, and each accepted output beat is checked
// field by field against the oldest one.
// ----------------------------------------------------------------------------
module rpvg_corner_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [31:0]            in_center_x,
  input  logic signed [31:0]            in_center_y,
  input  logic signed [31:0]            in_first_x,
  input  logic signed [31:0]            in_first_y,
  input  logic [rpvg_pkg::SIDE_W-1:0]   in_side_count,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [31:0]            out_corner_x,
  input  logic signed [31:0]            out_corner_y,
  input  logic [5:0]                    out_corner_index,
  input  logic                          out_last_corner,
  output int                            mismatches,
  output int                            corners_pending,
  output int                            corners_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import rpvg_pkg::*;

  localparam longint COORD_TOP = (longint'(1) <<< (COORD_WIDTH_DEF - 1)) - 1;
  localparam longint COORD_BOTTOM = -COORD_TOP - 1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [5:0]         pos;
    logic               last;
    logic [31:0]        item_no;
  } corner_t;

  corner_t expected_corners[$];
  int      items_taken;

  task automatic unit_rotation(input logic [31:0] turn, output longint c, output longint s);
    longint     x;
    longint     y;
    longint     z;
    longint     xs;
    longint     ys;
    int         i;
    rpvg_quad_t quad;
    x = CORDIC_GAIN;
    y = 0;
    z = longint'({2'b00, turn[29:0]});
    quad = rpvg_quad_t'(turn[31:30]);
    for (i = 0; i < ROTATION_STEPS_DEF; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (z >= 0) begin
        x = x - xs;
        y = y + ys;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + xs;
        y = y - ys;
        z = z + ATAN_TURN[i];
      end
    end
    case (quad)
      QUAD_II: begin
        c = -y;
        s = x;
      end
      QUAD_III: begin
        c = -x;
        s = -y;
      end
      QUAD_IV: begin
        c = y;
        s = -x;
      end
      default: begin
        c = x;
        s = y;
      end
    endcase
  endtask

  // Product of an offset and a Q2.30 factor, rounded half up to a coordinate.
  function automatic longint scale_q30(input longint d, input longint f);
    logic signed [95:0] p;
    p = d;
    p = p * f + 96'sd536870912;
    return longint'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > COORD_TOP) return COORD_TOP[31:0];
    if (v < COORD_BOTTOM) return COORD_BOTTOM[31:0];
    return v[31:0];
  endfunction

  task automatic note_mismatch(input string text);
    mismatches++;
    $display("rpvg checker: %s", text);
  endtask

  task automatic predict_polygon();
    longint      cx;
    longint      cy;
    longint      dx;
    longint      dy;
    longint      c;
    longint      s;
    int          n;
    int          k;
    logic [15:0] ang;
    corner_t     v;
    n = int'(in_side_count);
    if (n > MAX_SIDES_DEF) n = MAX_SIDES_DEF;
    cx = longint'(in_center_x);
    cy = longint'(in_center_y);
    dx = longint'(in_first_x) - cx;
    dy = longint'(in_first_y) - cy;
    for (k = 0; k < n; k++) begin
      if (k == 0) begin
        v.x = in_first_x;
        v.y = in_first_y;
      end else begin
        ang = 16'((k <<< 16) / n);
        unit_rotation({ang, 16'h0000}, c, s);
        v.x = clamp_coord(cx + scale_q30(dx, c) - scale_q30(dy, s));
        v.y = clamp_coord(cy + scale_q30(dx, s) + scale_q30(dy, c));
      end
      v.pos = 6'(k);
      v.last = (k == n - 1);
      v.item_no = items_taken;
      expected_corners.insert(expected_corners.size(), v);
    end
    items_taken++;
  endtask

  task automatic check_corner();
    corner_t want;
    string   tag;
    if (expected_corners.size() == 0) begin
      note_mismatch($sformatf("corner beat (index %0d) with nothing expected",
                              out_corner_index));
    end else begin
      want = expected_corners.pop_front();
      corners_seen++;
      tag = $sformatf("item %0d corner %0d:", want.item_no, want.pos);
      if (out_corner_x !== want.x)
        note_mismatch($sformatf("%s corner_x %0d, expected %0d", tag, out_corner_x, want.x));
      if (out_corner_y !== want.y)
        note_mismatch($sformatf("%s corner_y %0d, expected %0d", tag, out_corner_y, want.y));
      if (out_corner_index !== want.pos)
        note_mismatch($sformatf("%s corner_index %0d, expected %0d", tag, out_corner_index,
                                want.pos));
      if (out_last_corner !== want.last)
        note_mismatch($sformatf("%s last_corner %0b, expected %0b", tag, out_last_corner,
                                want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      corners_seen = 0;
      items_taken = 0;
    end else begin
      if (in_valid && in_ready) predict_polygon();
      if (out_valid && out_ready) check_corner();
    end
    corners_pending <= expected_corners.size();
  end

endmodule

/* tb/regular_polygon_vertex_generator_top_tb.sv */
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator_top_tb
// Stimulus and verdict for the regular polygon vertex generator.
// ----------------------------------------------------------------------------
// A short directed set covers zero and one side, small regular polygons, a
// vertex on the centre, saturating extremes and side counts at and above the
// limit. Random polygons follow, mostly small ones near a random centre, with
// fully random and extreme coordinates mixed in. Both channels idle at random,
// with some stretches at full rate. The checker module checks every beat.
// ----------------------------------------------------------------------------
module regular_polygon_vertex_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpvg_pkg::*;

  localparam int RANDOM_ITEMS = 440;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 1600;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic signed [31:0] in_first_x = '0;
  logic signed [31:0] in_first_y = '0;
  logic [SIDE_W-1:0]  in_side_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_corner_x;
  logic signed [31:0] out_corner_y;
  logic [5:0]         out_corner_index;
  logic               out_last_corner;

  int mismatches;
  int corners_pending;
  int corners_seen;
  int idle_cycles = 0;
  int ready_hold = 0;
  int items_sent = 0;
  int empty_items = 0;
  int clamped_items = 0;
  bit steady = 1'b0;

  always #5 clk = ~clk;

  regular_polygon_vertex_generator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_side_count    (in_side_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_corner_index (out_corner_index),
    .out_last_corner  (out_last_corner)
  );

  rpvg_corner_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_side_count    (in_side_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_corner_x     (out_corner_x),
    .out_corner_y     (out_corner_y),
    .out_corner_index (out_corner_index),
    .out_last_corner  (out_last_corner),
    .mismatches       (mismatches),
    .corners_pending  (corners_pending),
    .corners_seen     (corners_seen)
  );

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] spread(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] extreme_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SIDE_W-1:0] pick_sides();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return SIDE_W'(0);
    if (r < 8) return SIDE_W'(1);
    if (r < 70) return SIDE_W'($urandom_range(2, 12));
    if (r < 88) return SIDE_W'($urandom_range(13, 40));
    if (r < 96) return SIDE_W'($urandom_range(41, 64));
    return SIDE_W'($urandom_range(65, 127));
  endfunction

  task automatic send_polygon(input logic signed [31:0] cx, input logic signed [31:0] cy,
                              input logic signed [31:0] fx, input logic signed [31:0] fy,
                              input logic [SIDE_W-1:0] n);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_center_x <= cx;
    in_center_y <= cy;
    in_first_x <= fx;
    in_first_y <= fy;
    in_side_count <= n;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (n == 0) empty_items++;
    if (n > MAX_SIDES_DEF) clamped_items++;
  endtask

  // Result side: ready is held for random spells, sometimes long, and is set
  // high at the end of every spell within the steady stretches.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b0;
      ready_hold <= idle_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("rpvg run: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("regular_polygon_vertex_generator_top_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    int                 style;
    int                 j;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_polygon(32'sd0, 32'sd0, 32'sd0, 32'sd0, 7'd0);
    send_polygon(32'sd98304, -32'sd131072, 32'sd196608, 32'sd262144, 7'd1);
    send_polygon(32'sd0, 32'sd0, 32'sd65536, 32'sd0, 7'd2);
    send_polygon(32'sd0, 32'sd0, 32'sd65536, 32'sd0, 7'd3);
    send_polygon(32'sd0, 32'sd0, 32'sd65536, 32'sd0, 7'd4);
    send_polygon(32'sd0, 32'sd0, 32'sd65536, 32'sd0, 7'd5);
    send_polygon(32'sd0, 32'sd0, 32'sd0, 32'sd65536, 7'd6);
    send_polygon(32'sd0, 32'sd0, -32'sd65536, 32'sd65536, 7'd8);
    send_polygon(32'sd0, 32'sd0, 32'sd65536, -32'sd65536, 7'd12);
    send_polygon(32'sd655360, -32'sd475136, 32'sd819200, 32'sd196608, 7'd7);
    send_polygon(32'sd819200, 32'sd819200, 32'sd819200, 32'sd819200, 7'd5);
    send_polygon(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 7'd4);
    send_polygon(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7'd3);
    send_polygon(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 7'd6);
    send_polygon(-32'sd1, 32'sd1, 32'sd0, 32'sd0, 7'd9);
    send_polygon(32'sd3276800, -32'sd1638400, 32'sd6553600, 32'sd0, 7'd63);
    send_polygon(-32'sd3276800, 32'sd1638400, 32'sd0, 32'sd6553600, 7'd64);
    send_polygon(32'sd131072, 32'sd65536, 32'sd196608, -32'sd65536, 7'd65);
    send_polygon(32'sh0123_4567, 32'sh7654_3210, 32'sh0133_4567, 32'sh7650_0000, 7'd127);
    send_polygon(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678, -32'sd5, 7'd0);
    send_polygon(32'sd0, 32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 7'd1);

    for (j = 0; j < RANDOM_ITEMS; j++) begin
      steady = ((j / 40) % 5 == 4);
      style = $urandom_range(0, 99);
      if (style < 60) begin
        cx = spread(1 << 24);
        cy = spread(1 << 24);
        fx = cx + spread(1 << 20);
        fy = cy + spread(1 << 20);
      end else if (style < 85) begin
        cx = $urandom;
        cy = $urandom;
        fx = $urandom;
        fy = $urandom;
      end else begin
        cx = extreme_coord();
        cy = extreme_coord();
        fx = extreme_coord();
        fy = extreme_coord();
      end
      send_polygon(cx, cy, fx, fy, pick_sides());
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (corners_pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("rpvg run: %0d polygons sent, %0d of them empty and %0d over the side limit",
             items_sent, empty_items, clamped_items);
    $display("rpvg run: %0d corners compared, %0d mismatches", corners_seen, mismatches);
    if (mismatches == 0) begin
      $display("regular_polygon_vertex_generator_top_tb: clean");
    end else begin
      $display("regular_polygon_vertex_generator_top_tb: errors");
    end
    $finish;
  end

endmodule

/* regular_polygon_vertex_generator_top.f */
design/rpvg_pkg.sv
design/rpvg_cordic_cell.sv
design/rpvg_cordic_chain.sv
design/rpvg_turn_gen.sv
design/regular_polygon_vertex_generator_top.sv
design/rpvg_checker.sv
tb/rpvg_corner_checker.sv
tb/regular_polygon_vertex_generator_top_tb.sv
